[rtl/core/kli_pkg.sv]
// Package for the keyframe linear interpolator.
// Holds command codes, widths and the transaction payload structs.
// No dependencies.
package kli_pkg;

  localparam int unsigned NumComp  = 9;
  localparam int unsigned CompSlot = 16;  // components per key row in the value memory

  localparam logic [1:0] CMD_LOAD_TIME = 2'd0;
  localparam logic [1:0] CMD_LOAD_COMP = 2'd1;
  localparam logic [1:0] CMD_QUERY     = 2'd2;

  typedef struct packed {
    logic [1:0]         command;
    logic [5:0]         key_index;
    logic [31:0]        key_time;
    logic [2:0]         use_mask;
    logic [3:0]         component_index;
    logic signed [31:0] component_value;
    logic [31:0]        query_time;
  } in_item_t;

  typedef struct packed {
    logic               found;
    logic [31:0]        sample_time;
    logic [2:0]         out_mask;
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic signed [31:0] pos_z;
    logic signed [31:0] rot_x;
    logic signed [31:0] rot_y;
    logic signed [31:0] rot_z;
    logic signed [31:0] scale_x;
    logic signed [31:0] scale_y;
    logic signed [31:0] scale_z;
  } out_item_t;

  typedef struct packed {
    logic [31:0] key_time;
    logic [2:0]  use_mask;
  } time_entry_t;

endpackage

[rtl/core/kli_if.sv]
// Valid/ready channel interfaces for the keyframe linear interpolator.
// Depends on kli_pkg.
interface kli_in_if;
  logic              valid;
  logic              ready;
  kli_pkg::in_item_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface kli_out_if;
  logic               valid;
  logic               ready;
  kli_pkg::out_item_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface kli_cfg_if;
  logic       valid;
  logic       ready;
  logic [6:0] data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

[rtl/core/kli_div.sv]
// Bit-serial divider for the interpolation fraction: floor(ctime * 2^16 / ftime).
// Requires ctime <= ftime; one quotient bit per cycle. No dependencies.
module kli_div (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic [31:0] dividend_i,
  input  logic [31:0] divisor_i,
  output logic        done_o,
  output logic [16:0] quot_o
);

  logic [32:0] rem_q, rem_d;
  logic [31:0] dvs_q;
  logic [16:0] quot_q, quot_d;
  logic [4:0]  cnt_q, cnt_d;
  logic        busy_q, busy_d;
  logic        done_q, done_d;
  logic        ge;
  logic [32:0] rdiff;

  assign ge    = rem_q >= {1'b0, dvs_q};
  assign rdiff = ge ? (rem_q - {1'b0, dvs_q}) : rem_q;

  always_comb begin
    rem_d  = rem_q;
    quot_d = quot_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    if (start_i) begin
      rem_d  = {1'b0, dividend_i};
      quot_d = '0;
      cnt_d  = '0;
      busy_d = 1'b1;
    end else if (busy_q) begin
      rem_d  = {rdiff[31:0], 1'b0};
      quot_d = {quot_q[15:0], ge};
      cnt_d  = cnt_q + 5'd1;
      if (cnt_q == 5'd16) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q  <= rem_d;
    quot_q <= quot_d;
    if (start_i) begin
      dvs_q <= divisor_i;
    end
  end

  assign done_o = done_q;
  assign quot_o = quot_q;

endmodule

[rtl/core/keyframe_linear_interpolator.sv]
// Keyframe linear interpolator: key table in two synchronous memories, query sequencer.
// Depends on kli_pkg, kli_if (kli_in_if, kli_out_if, kli_cfg_if) and kli_div.
//
// Usage:
//   cfg_i   : writes key_count (always ready). Write only while the block is idle.
//   in_i    : one transaction per command. Load commands write the time/mask memory
//             or the component memory in the accept cycle and give no result.
//             A query gives exactly one transaction on out_o.
//   out_o   : result register; a finished result waits there until taken.
// Sequence:
//   Loads finish in the accept cycle. A query with fewer than two keys goes
//   from the accept cycle straight to loading the result register. Otherwise:
//   the accept cycle, a memory read and a compare per key time scanned, a read
//   and a wait for the start key, the serial divider, and for each of the nine
//   components a lerp of two value reads, multiply and writeback, then the load
//   of the result register, after which the next transaction can be accepted.
//   in_i.ready is low while a query is in flight; a stalled receiver holds the
//   sequencer in its last state until the result register frees up.
// Reset: key_count returns to 0 and control clears; memory contents are
//   undefined until written.
module keyframe_linear_interpolator #(
  parameter int unsigned MAX_KEYS = 64
) (
  input  logic clk_i,
  input  logic rst_ni,
  kli_cfg_if.sink   cfg_i,
  kli_in_if.sink    in_i,
  kli_out_if.source out_o
);

  localparam int unsigned IdxW  = $clog2(MAX_KEYS);
  localparam int unsigned CntW  = $clog2(MAX_KEYS + 1);
  localparam int unsigned VAddW = IdxW + $clog2(kli_pkg::CompSlot);

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_SRD  = 4'd1;
  localparam logic [3:0] S_SCMP = 4'd2;
  localparam logic [3:0] S_TSRD = 4'd3;
  localparam logic [3:0] S_TSWT = 4'd4;
  localparam logic [3:0] S_DIV  = 4'd5;
  localparam logic [3:0] S_CRDA = 4'd6;
  localparam logic [3:0] S_CRDB = 4'd7;
  localparam logic [3:0] S_CMUL = 4'd8;
  localparam logic [3:0] S_CWR  = 4'd9;
  localparam logic [3:0] S_OUT  = 4'd10;

  // memories
  kli_pkg::time_entry_t tmem [MAX_KEYS];
  logic [31:0]          vmem [MAX_KEYS * kli_pkg::CompSlot];

  kli_pkg::time_entry_t tm_rdata;
  logic [IdxW-1:0]      tm_raddr;
  logic [31:0]          vm_rdata;
  logic [VAddW-1:0]     vm_raddr;

  logic [3:0]      state_q, state_d;
  logic [6:0]      key_count_q;
  logic [CntW-1:0] n;
  logic [31:0]     n_full, kidx_w;
  logic [IdxW-1:0] i_q, st_q, en_q;
  logic [31:0]     t_q, tend_q;
  logic [2:0]      mask_q;
  logic            found_q, fzero_q;
  logic [16:0]     f_q;
  logic [3:0]      c_q;
  logic [31:0]     a_q;
  logic signed [50:0] prod_q;
  logic [31:0]     res_q [kli_pkg::NumComp];
  logic            out_valid_q;
  kli_pkg::out_item_t out_q;

  logic        in_acc, load_ok;
  logic        div_start, div_done;
  logic [16:0] div_quot;
  logic [31:0] ts_w, ftime_w, ctime_w;
  logic signed [32:0] diff_w;
  logic [IdxW-1:0] last_w;

  assign cfg_i.ready = 1'b1;
  assign in_i.ready  = (state_q == S_IDLE);
  assign in_acc      = in_i.valid && in_i.ready;

  assign n_full = (32'(key_count_q) > 32'(MAX_KEYS)) ? 32'(MAX_KEYS) : 32'(key_count_q);
  assign n      = n_full[CntW-1:0];
  assign last_w = IdxW'(n_full - 32'd1);
  assign kidx_w = 32'(in_i.data.key_index);
  assign load_ok = kidx_w < 32'(MAX_KEYS);

  // memory ports
  always_ff @(posedge clk_i) begin
    if (in_acc && load_ok && in_i.data.command == kli_pkg::CMD_LOAD_TIME) begin
      tmem[kidx_w[IdxW-1:0]] <= '{key_time: in_i.data.key_time,
                                  use_mask: in_i.data.use_mask};
    end
    tm_rdata <= tmem[tm_raddr];
  end

  always_ff @(posedge clk_i) begin
    if (in_acc && load_ok && in_i.data.command == kli_pkg::CMD_LOAD_COMP &&
        in_i.data.component_index < 4'(kli_pkg::NumComp)) begin
      vmem[{kidx_w[IdxW-1:0], in_i.data.component_index}] <= in_i.data.component_value;
    end
    vm_rdata <= vmem[vm_raddr];
  end

  assign tm_raddr = (state_q == S_TSRD) ? st_q : i_q;
  assign vm_raddr = (state_q == S_CRDB) ? {en_q, c_q} : {st_q, c_q};

  assign ts_w    = tm_rdata.key_time;
  assign ftime_w = tend_q - ts_w;
  assign ctime_w = t_q - ts_w;
  assign div_start = (state_q == S_TSWT);
  assign diff_w  = $signed({vm_rdata[31], vm_rdata}) - $signed({a_q[31], a_q});

  kli_div u_div (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (div_start),
    .dividend_i(ctime_w),
    .divisor_i (ftime_w),
    .done_o    (div_done),
    .quot_o    (div_quot)
  );

  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (in_acc && in_i.data.command == kli_pkg::CMD_QUERY) begin
          state_d = (n < CntW'(2)) ? S_OUT : S_SRD;
        end
      end
      S_SRD:  state_d = S_SCMP;
      S_SCMP: begin
        if (t_q < tm_rdata.key_time || i_q == last_w) begin
          state_d = S_TSRD;
        end else begin
          state_d = S_SRD;
        end
      end
      S_TSRD: state_d = S_TSWT;
      S_TSWT: state_d = S_DIV;
      S_DIV:  state_d = div_done ? S_CRDA : S_DIV;
      S_CRDA: state_d = S_CRDB;
      S_CRDB: state_d = S_CMUL;
      S_CMUL: state_d = S_CWR;
      S_CWR:  state_d = (c_q == 4'(kli_pkg::NumComp - 1)) ? S_OUT : S_CRDA;
      S_OUT:  state_d = (!out_valid_q || out_o.ready) ? S_IDLE : S_OUT;
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      key_count_q <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cfg_i.valid) begin
        key_count_q <= cfg_i.data;
      end
      if (state_q == S_OUT && (!out_valid_q || out_o.ready)) begin
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // datapath
  always_ff @(posedge clk_i) begin
    case (state_q)
      S_IDLE: begin
        t_q     <= in_i.data.query_time;
        i_q     <= IdxW'(1);
        found_q <= (n >= CntW'(2));
      end
      S_SCMP: begin
        en_q   <= i_q;
        st_q   <= i_q - IdxW'(1);
        tend_q <= tm_rdata.key_time;
        mask_q <= tm_rdata.use_mask;
        if (!(t_q < tm_rdata.key_time)) begin
          // past the last key: clamp to its time
          if (i_q == last_w) begin
            t_q <= tm_rdata.key_time;
          end
          i_q <= i_q + IdxW'(1);
        end
      end
      S_TSWT: begin
        fzero_q <= (t_q < ts_w) || (ftime_w == 32'd0);
        c_q     <= '0;
      end
      S_DIV: begin
        f_q <= fzero_q ? 17'd0 : div_quot;
      end
      S_CRDB: a_q <= vm_rdata;
      S_CMUL: prod_q <= (51'(diff_w) * 51'($signed({1'b0, f_q}))) + 51'sd32768;
      S_CWR: begin
        res_q[c_q] <= a_q + prod_q[47:16];
        c_q        <= c_q + 4'd1;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (state_q == S_OUT && (!out_valid_q || out_o.ready)) begin
      out_q.found       <= found_q;
      out_q.sample_time <= found_q ? t_q : 32'd0;
      out_q.out_mask    <= found_q ? mask_q : 3'd0;
      out_q.pos_x   <= (found_q && mask_q[0]) ? res_q[0] : 32'd0;
      out_q.pos_y   <= (found_q && mask_q[0]) ? res_q[1] : 32'd0;
      out_q.pos_z   <= (found_q && mask_q[0]) ? res_q[2] : 32'd0;
      out_q.rot_x   <= (found_q && mask_q[1]) ? res_q[3] : 32'd0;
      out_q.rot_y   <= (found_q && mask_q[1]) ? res_q[4] : 32'd0;
      out_q.rot_z   <= (found_q && mask_q[1]) ? res_q[5] : 32'd0;
      out_q.scale_x <= (found_q && mask_q[2]) ? res_q[6] : 32'd0;
      out_q.scale_y <= (found_q && mask_q[2]) ? res_q[7] : 32'd0;
      out_q.scale_z <= (found_q && mask_q[2]) ? res_q[8] : 32'd0;
    end
  end

  assign out_o.valid = out_valid_q;
  assign out_o.data  = out_q;

endmodule
